// ===== hw/rtl/mfac_pkg.sv =====
// Shared types, constants and helpers for the model-free adaptive controller.
package mfac_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned WideW = 64;

  // register indexes on the configuration port
  localparam logic [7:0] CFG_STEP_GAIN       = 8'd0;
  localparam logic [7:0] CFG_UPDATE_DAMPING  = 8'd1;
  localparam logic [7:0] CFG_CONTROL_DAMPING = 8'd2;
  localparam logic [7:0] CFG_WEIGHT_0        = 8'd3;
  localparam logic [7:0] CFG_WEIGHT_1        = 8'd4;
  localparam logic [7:0] CFG_WEIGHT_2        = 8'd5;

  // reset values, Q16.16
  localparam logic [17:0] RST_STEP_GAIN  = 18'd13107;
  localparam logic [30:0] RST_UPD_DAMP   = 31'd65536;
  localparam logic [30:0] RST_CTL_DAMP   = 31'd458752;
  localparam logic [16:0] RST_WEIGHT     = 17'd45875;
  localparam logic [31:0] RST_PREV_OUT   = 32'd13107;
  localparam logic [31:0] RST_PREV_CTL   = 32'd32768;
  localparam logic [31:0] RST_DY_HIST    = 32'hFFFF_3333;  // -0.8
  localparam logic [31:0] RST_DU_HIST0   = 32'd32768;
  localparam logic [31:0] RST_DU_HIST1   = 32'd0;
  localparam logic [31:0] RST_PHI0       = 32'hFFFE_0000;  // -2
  localparam logic [31:0] RST_PHI1       = 32'd32768;
  localparam logic [31:0] RST_PHI2       = 32'd13107;

  localparam logic [63:0] DIV_Q16 = 64'h0000_0000_0001_0000;
  localparam logic [63:0] DIV_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] DIV_ONE = 64'd1;
  localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [63:0]        d;
  } md_req_t;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_e;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_FINISH} st_e;

  typedef enum logic [4:0] {
    OP_SQ0, OP_SQ1, OP_SQ2, OP_DOT0, OP_DOT1, OP_DOT2, OP_DEN,
    OP_T0, OP_S0, OP_T1, OP_S1, OP_T2, OP_S2,
    OP_ERR, OP_WP0, OP_BR0, OP_WP2, OP_BR2, OP_SQL, OP_U
  } op_e;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] sx32(input logic signed [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic signed [65:0] sx66(input logic signed [63:0] x);
    return {{2{x[63]}}, x};
  endfunction

  function automatic logic ovf32(input logic signed [65:0] x);
    return !((&x[65:31]) || !(|x[65:31]));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (!ovf32(x)) r = x[31:0];
    else if (x[65]) r = 32'sh8000_0000;
    else r = 32'sh7FFF_FFFF;
    return r;
  endfunction

endpackage

// ===== hw/rtl/mfac_muldiv.sv =====
// Shared bit-serial unit: trunc(a*b/d) with an exact 128-bit product, saturating.
module mfac_muldiv import mfac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  md_req_t            req_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  md_state_e          st_q, st_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [63:0]        a_q, a_d, b_q, b_d, d_q, d_d, hi_q, hi_d, lo_q, lo_d;
  logic               neg_q, neg_d, done_q, done_d;
  logic signed [63:0] res_q, res_d;

  logic [64:0] sum;
  logic [63:0] rem, lo_n, qmag, qsh;
  logic        carry, pow2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MD_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    d_q   <= d_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    d_d    = d_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    neg_d  = neg_q;
    res_d  = res_q;
    done_d = 1'b0;
    sum    = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : 65'd0);
    carry  = hi_q[63];
    rem    = {hi_q[62:0], lo_q[63]};
    lo_n   = {lo_q[62:0], 1'b0};
    if (carry || rem >= d_q) begin
      rem     = rem - d_q;
      lo_n[0] = 1'b1;
    end
    qmag = lo_n[63] ? MAG_MAX : lo_n;
    // power-of-two divisors are a plain shift of the product
    pow2 = (d_q == DIV_ONE) || (d_q == DIV_Q16) || (d_q == DIV_Q32);
    if (d_q == DIV_Q32) qsh = {hi_q[31:0], lo_q[63:32]};
    else if (d_q == DIV_Q16) qsh = {hi_q[15:0], lo_q[63:16]};
    else qsh = lo_q;
    if (qsh[63]) qsh = MAG_MAX;
    case (st_q)
      MD_IDLE: begin
        if (start_i) begin
          a_d   = mag64(req_i.a);
          b_d   = mag64(req_i.b);
          d_d   = req_i.d;
          neg_d = req_i.a[63] ^ req_i.b[63];
          hi_d  = '0;
          lo_d  = '0;
          cnt_d = '0;
          st_d  = MD_MUL;
        end
      end
      MD_MUL: begin
        // shift-add, product builds in {hi, lo}
        hi_d  = sum[64:1];
        lo_d  = {sum[0], lo_q[63:1]};
        b_d   = {1'b0, b_q[63:1]};
        cnt_d = cnt_q + 6'd1;
        if (&cnt_q) st_d = MD_DIV;
      end
      MD_DIV: begin
        if (cnt_q == 6'd0 && hi_q >= d_q) begin
          // quotient would not fit in 64 bits
          res_d  = neg_q ? 64'(-MAG_MAX) : MAG_MAX;
          done_d = 1'b1;
          st_d   = MD_IDLE;
        end else if (cnt_q == 6'd0 && pow2) begin
          res_d  = neg_q ? 64'(-qsh) : qsh;
          done_d = 1'b1;
          st_d   = MD_IDLE;
        end else begin
          hi_d  = rem;
          lo_d  = lo_n;
          cnt_d = cnt_q + 6'd1;
          if (&cnt_q) begin
            res_d  = neg_q ? 64'(-qmag) : qmag;
            done_d = 1'b1;
            st_d   = MD_IDLE;
          end
        end
      end
      default: st_d = MD_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hw/rtl/model_free_adaptive_controller_top.sv =====
// Top level: full-form dynamic linearization model-free adaptive controller.
// Each word runs 15 unit passes with a power-of-two divisor (shift-add steps, then one shift)
//   and 4 with a data divisor (shift-add steps, then division steps), in sequencer order.
// s_axis_tready_o is high only while idle, so no new word is taken while the last is in work.
// The result sits in an output register, so a new word may enter while it waits.
// Reset (rst_ni low, async): configuration registers and controller state take their reset values.
module model_free_adaptive_controller_top import mfac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] setpoint, [63:32] measured
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] control_value
  output logic        m_axis_tuser_o,   // [0] saturated
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // configuration; weight_3 and weight_4 do not enter the control law at these
  // orders, so their writes are acknowledged and dropped
  logic [17:0] eta_q;
  logic [30:0] mu_q, lam_q;
  logic [16:0] w0_q, w1_q, w2_q;

  // controller state
  logic signed [31:0] prev_y_q, prev_y_d, prev_u_q, prev_u_d;
  logic signed [31:0] dyh_q, dyh_d, du0_q, du0_d, du1_q, du1_d;
  logic signed [31:0] phi0_q, phi0_d, phi1_q, phi1_d, phi2_q, phi2_d;

  // per-word scratch
  st_e                st_q, st_d;
  op_e                op_q, op_d;
  logic signed [31:0] sp_q, sp_d, ms_q, ms_d, dy_q, dy_d;
  logic [48:0]        norm_q, norm_d;
  logic [46:0]        lsq_q, lsq_d;
  logic signed [63:0] dot_q, dot_d, err_q, err_d, tmp_q, tmp_d, br_q, br_d;
  logic [63:0]        den_q, den_d;
  logic               flag_q, flag_d;

  // output register
  logic               mv_q, mv_d;
  logic signed [31:0] mdata_q, mdata_d;
  logic               muser_q, muser_d;

  logic               md_start, md_done;
  md_req_t            md_req;
  logic signed [63:0] md_res;

  logic signed [65:0] wsum, dsum;
  logic signed [31:0] unew, dunew, phinew;
  logic [30:0]        mu_eff, lam_eff;
  logic signed [32:0] sp_err;

  mfac_muldiv u_md (
    .clk_i,
    .rst_ni,
    .start_i (md_start),
    .req_i   (md_req),
    .done_o  (md_done),
    .res_o   (md_res)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_q <= RST_STEP_GAIN;
      mu_q  <= RST_UPD_DAMP;
      lam_q <= RST_CTL_DAMP;
      w0_q  <= RST_WEIGHT;
      w1_q  <= RST_WEIGHT;
      w2_q  <= RST_WEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STEP_GAIN:       eta_q <= cfg_data_i[17:0];
        CFG_UPDATE_DAMPING:  mu_q  <= cfg_data_i[30:0];
        CFG_CONTROL_DAMPING: lam_q <= cfg_data_i[30:0];
        CFG_WEIGHT_0:        w0_q  <= cfg_data_i[16:0];
        CFG_WEIGHT_1:        w1_q  <= cfg_data_i[16:0];
        CFG_WEIGHT_2:        w2_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      op_q     <= OP_SQ0;
      mv_q     <= 1'b0;
      prev_y_q <= RST_PREV_OUT;
      prev_u_q <= RST_PREV_CTL;
      dyh_q    <= RST_DY_HIST;
      du0_q    <= RST_DU_HIST0;
      du1_q    <= RST_DU_HIST1;
      phi0_q   <= RST_PHI0;
      phi1_q   <= RST_PHI1;
      phi2_q   <= RST_PHI2;
    end else begin
      st_q     <= st_d;
      op_q     <= op_d;
      mv_q     <= mv_d;
      prev_y_q <= prev_y_d;
      prev_u_q <= prev_u_d;
      dyh_q    <= dyh_d;
      du0_q    <= du0_d;
      du1_q    <= du1_d;
      phi0_q   <= phi0_d;
      phi1_q   <= phi1_d;
      phi2_q   <= phi2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q    <= sp_d;
    ms_q    <= ms_d;
    dy_q    <= dy_d;
    norm_q  <= norm_d;
    lsq_q   <= lsq_d;
    dot_q   <= dot_d;
    err_q   <= err_d;
    tmp_q   <= tmp_d;
    br_q    <= br_d;
    den_q   <= den_d;
    flag_q  <= flag_d;
    mdata_q <= mdata_d;
    muser_q <= muser_d;
  end

  // a damping of zero counts as one LSB so no divisor is zero
  assign mu_eff  = (mu_q == '0) ? 31'd1 : mu_q;
  assign lam_eff = (lam_q == '0) ? 31'd1 : lam_q;
  assign sp_err  = {sp_q[31], sp_q} - {ms_q[31], ms_q};

  // operand select for the shared unit
  always_comb begin
    md_req = '0;
    case (op_q)
      OP_SQ0:  md_req = '{sx32(dyh_q), sx32(dyh_q), DIV_Q16};
      OP_SQ1:  md_req = '{sx32(du0_q), sx32(du0_q), DIV_Q16};
      OP_SQ2:  md_req = '{sx32(du1_q), sx32(du1_q), DIV_Q16};
      OP_DOT0: md_req = '{sx32(phi0_q), sx32(dyh_q), DIV_Q16};
      OP_DOT1: md_req = '{sx32(phi1_q), sx32(du0_q), DIV_Q16};
      OP_DOT2: md_req = '{sx32(phi2_q), sx32(du1_q), DIV_Q16};
      OP_T0:   md_req = '{err_q, sx32(dyh_q), den_q};
      OP_T1:   md_req = '{err_q, sx32(du0_q), den_q};
      OP_T2:   md_req = '{err_q, sx32(du1_q), den_q};
      OP_S0, OP_S1, OP_S2: md_req = '{tmp_q, {46'd0, eta_q}, DIV_Q16};
      OP_ERR:  md_req = '{{47'd0, w1_q}, {{31{sp_err[32]}}, sp_err}, DIV_Q16};
      OP_WP0:  md_req = '{{47'd0, w0_q}, sx32(phi0_q), DIV_ONE};
      OP_BR0:  md_req = '{tmp_q, sx32(dyh_q), DIV_Q32};
      OP_WP2:  md_req = '{{47'd0, w2_q}, sx32(phi2_q), DIV_ONE};
      OP_BR2:  md_req = '{tmp_q, sx32(du0_q), DIV_Q32};
      OP_SQL:  md_req = '{sx32(phi1_q), sx32(phi1_q), DIV_Q16};
      OP_U:    md_req = '{sx32(phi1_q), br_q, {33'd0, lam_eff} + {17'd0, lsq_q}};
      default: md_req = '0;
    endcase
  end

  always_comb begin
    st_d = st_q;  op_d = op_q;  mv_d = mv_q;
    prev_y_d = prev_y_q;  prev_u_d = prev_u_q;
    dyh_d = dyh_q;  du0_d = du0_q;  du1_d = du1_q;
    phi0_d = phi0_q;  phi1_d = phi1_q;  phi2_d = phi2_q;
    sp_d = sp_q;  ms_d = ms_q;  dy_d = dy_q;  norm_d = norm_q;  lsq_d = lsq_q;
    dot_d = dot_q;  err_d = err_q;  tmp_d = tmp_q;  br_d = br_q;  den_d = den_q;
    flag_d = flag_q;  mdata_d = mdata_q;  muser_d = muser_q;
    md_start = 1'b0;
    s_axis_tready_o = (st_q == ST_IDLE);

    // gradient entry update: phi_i + step, clipped
    phinew = '0;
    case (op_q)
      OP_S0:   phinew = sat32(sx66(sx32(phi0_q)) + sx66(md_res));
      OP_S1:   phinew = sat32(sx66(sx32(phi1_q)) + sx66(md_res));
      default: phinew = sat32(sx66(sx32(phi2_q)) + sx66(md_res));
    endcase
    case (op_q)
      OP_S0:   wsum = sx66(sx32(phi0_q)) + sx66(md_res);
      OP_S1:   wsum = sx66(sx32(phi1_q)) + sx66(md_res);
      OP_S2:   wsum = sx66(sx32(phi2_q)) + sx66(md_res);
      default: wsum = sx66(sx32(prev_u_q)) + sx66(md_res);
    endcase
    unew  = sat32(wsum);
    dsum  = sx66(sx32(unew)) - sx66(sx32(prev_u_q));
    dunew = sat32(dsum);

    if (mv_q && m_axis_tready_i) mv_d = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          sp_d   = s_axis_tdata_i[31:0];
          ms_d   = s_axis_tdata_i[63:32];
          dsum   = sx66(sx32(s_axis_tdata_i[63:32])) - sx66(sx32(prev_y_q));
          dy_d   = sat32(dsum);
          flag_d = ovf32(dsum);
          norm_d = '0;
          dot_d  = '0;
          op_d   = OP_SQ0;
          st_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (op_q == OP_DEN) begin
          den_d = {33'd0, mu_eff} + {15'd0, norm_q};
          err_d = sx32(dy_q) - dot_q;
          op_d  = OP_T0;
        end else begin
          md_start = 1'b1;
          st_d     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (md_done) begin
          st_d = ST_RUN;
          op_d = op_e'(op_q + 5'd1);
          case (op_q)
            OP_SQ0, OP_SQ1, OP_SQ2:   norm_d = norm_q + md_res[48:0];
            OP_DOT0, OP_DOT1, OP_DOT2: dot_d = dot_q + md_res;
            OP_T0, OP_T1, OP_T2, OP_WP0, OP_WP2: tmp_d = md_res;
            OP_S0: begin
              phi0_d = phinew;
              flag_d = flag_q | ovf32(wsum);
            end
            OP_S1: begin
              phi1_d = phinew;
              flag_d = flag_q | ovf32(wsum);
            end
            OP_S2: begin
              phi2_d = phinew;
              flag_d = flag_q | ovf32(wsum);
            end
            OP_ERR: begin
              br_d  = md_res;
              dyh_d = dy_q;  // newest output difference enters the history
            end
            OP_BR0, OP_BR2: br_d = br_q - md_res;
            OP_SQL: lsq_d = md_res[46:0];
            OP_U: begin
              prev_u_d = unew;
              du1_d    = du0_q;
              du0_d    = dunew;
              prev_y_d = ms_q;
              flag_d   = flag_q | ovf32(wsum) | ovf32(dsum);
              op_d     = OP_SQ0;
              st_d     = ST_FINISH;
            end
            default: ;
          endcase
        end
      end
      ST_FINISH: begin
        // park here until the output register is free
        if (!mv_q || m_axis_tready_i) begin
          mdata_d = prev_u_q;
          muser_d = flag_q;
          mv_d    = 1'b1;
          st_d    = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = muser_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> st_q == ST_WAIT) else $error("unit finished outside wait");

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> st_q == ST_RUN && op_q == OP_SQ0)
    else $error("accepted word did not start the sequence");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(st_q) == ST_FINISH)
    else $error("result shown without finishing");

endmodule

// ===== dv/tb_model_free_adaptive_controller_top.sv =====
// Self-checking testbench for the model-free adaptive controller top level.
module tb_model_free_adaptive_controller_top import mfac_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // registers beyond the package list, and one index the block must ignore
  localparam logic [7:0] CFG_WEIGHT_3 = 8'd6;
  localparam logic [7:0] CFG_WEIGHT_4 = 8'd7;
  localparam logic [7:0] CFG_UNMAPPED = 8'd9;

  localparam int unsigned IdleLimit   = 40000;  // covers the hold-off
  localparam int unsigned HoldCycles  = 7000;   // receiver hold-off
  localparam int unsigned DrainCycles = 3000;
  localparam int unsigned RandPerPhase = 90;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;   // [31:0] setpoint, [63:32] measured
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [31:0] control_value
  logic        m_axis_tuser_o;   // [0] saturated
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  model_free_adaptive_controller_top i_dut (.*);

  // ---------------------------------------------------------------------------
  // Controller shadow: configuration and state; state is updated per accepted word
  // ---------------------------------------------------------------------------
  logic        [17:0] eta_q;
  logic        [30:0] mu_q;
  logic        [30:0] lambda_q;
  logic        [16:0] rho_q [5];
  logic signed [31:0] prev_y_q, prev_u_q, dy_hist_q;
  logic signed [31:0] du_hist_q [2];
  logic signed [31:0] phi_q [3];

  typedef struct {
    logic signed [31:0] control;
    logic               sat;
    logic               fixed_sat;   // directed row with a known flag
    logic               known_sat;
  } control_exp_t;

  control_exp_t pending_controls[$];

  int unsigned mismatches;
  int unsigned send_idle_pct, recv_stall_pct;
  logic        recv_hold;
  int unsigned quiet_cycles;
  logic signed [31:0] last_measured;

  // trunc(a*b/d) on the exact product, magnitude clamped to 2^63-1
  function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input logic [63:0] d);
    logic [63:0]  ua, ub, mag;
    logic [127:0] quo;
    logic         neg;
    neg = a[63] ^ b[63];
    ua  = a[63] ? 64'(-a) : 64'(a);
    ub  = b[63] ? 64'(-b) : 64'(b);
    quo = ({64'd0, ua} * {64'd0, ub}) / {64'd0, d};
    mag = (quo > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : quo[63:0];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [63:0] square_q16(input logic signed [63:0] x);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    return (m * m) >> 16;
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [65:0] x,
                                                output logic ovf);
    ovf = 1'b1;
    if (x > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -66'sd2147483648) return 32'sh8000_0000;
    ovf = 1'b0;
    return x[31:0];
  endfunction

  task automatic reset_controller_shadow();
    eta_q = 18'd13107;
    mu_q = 31'd65536;
    lambda_q = 31'd458752;
    for (int i = 0; i < 5; i++) rho_q[i] = 17'd45875;
    prev_y_q = 32'sd13107;
    prev_u_q = 32'sd32768;
    dy_hist_q = -32'sd52429;
    du_hist_q[0] = 32'sd32768;
    du_hist_q[1] = 32'sd0;
    phi_q[0] = -32'sd131072;
    phi_q[1] = 32'sd32768;
    phi_q[2] = 32'sd13107;
  endtask

  // One control sample: gradient update, then the control law.
  task automatic predict_control(input logic signed [31:0] setpoint,
                                 input logic signed [31:0] measured,
                                 output logic signed [31:0] u_new,
                                 output logic sat);
    logic signed [63:0] h [3];
    logic signed [63:0] dot, err, t, s, bracket, lead, wp0, wp2;
    logic        [63:0] norm, den;
    logic signed [31:0] dy, du;
    logic               o;
    sat = 1'b0;
    h[0] = dy_hist_q;
    h[1] = du_hist_q[0];
    h[2] = du_hist_q[1];
    dy = clip32(66'(measured) - 66'(prev_y_q), o);
    sat |= o;
    norm = '0;
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      norm += square_q16(h[i]);
      dot  += scaled_product(phi_q[i], h[i], DIV_Q16);
    end
    den = 64'((mu_q == '0) ? 31'd1 : mu_q) + norm;
    err = 64'(dy) - dot;
    for (int i = 0; i < 3; i++) begin
      t = scaled_product(err, h[i], den);
      s = scaled_product(t, $signed({46'd0, eta_q}), DIV_Q16);
      phi_q[i] = clip32(66'(phi_q[i]) + 66'(s), o);
      sat |= o;
    end
    dy_hist_q = dy;

    bracket = scaled_product($signed({47'd0, rho_q[1]}), 64'(setpoint) - 64'(measured),
                             DIV_Q16);
    wp0 = $signed({47'd0, rho_q[0]}) * 64'(phi_q[0]);
    wp2 = $signed({47'd0, rho_q[2]}) * 64'(phi_q[2]);
    bracket -= scaled_product(wp0, 64'(dy_hist_q), DIV_Q32);
    bracket -= scaled_product(wp2, 64'(du_hist_q[0]), DIV_Q32);

    lead = 64'(phi_q[1]);
    den = 64'((lambda_q == '0) ? 31'd1 : lambda_q) + square_q16(lead);
    u_new = clip32(66'(prev_u_q) + 66'(scaled_product(lead, bracket, den)), o);
    sat |= o;
    du = clip32(66'(u_new) - 66'(prev_u_q), o);
    sat |= o;
    du_hist_q[1] = du_hist_q[0];
    du_hist_q[0] = du;
    prev_u_q = u_new;
    prev_y_q = measured;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure plus an optional long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready_i <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    control_exp_t e;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_controls.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] control word with none expected: %h sat %b",
                   $realtime, m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        e = pending_controls.pop_front();
        if ($signed(m_axis_tdata_o) !== e.control || m_axis_tuser_o !== e.sat ||
            (e.fixed_sat && m_axis_tuser_o !== e.known_sat)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] control exp %h sat %b, got %h sat %b", $realtime,
                     e.control, e.sat, m_axis_tdata_o, m_axis_tuser_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic signed [31:0] setpoint,
                             input logic signed [31:0] measured,
                             input logic fixed_sat, input logic known_sat);
    control_exp_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {measured, setpoint};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_control(setpoint, measured, e.control, e.sat);
    e.fixed_sat = fixed_sat;
    e.known_sat = known_sat;
    pending_controls = {pending_controls, e};
    last_measured = measured;
  endtask

  // Let every pending control word come back, then a short guard.
  task automatic drain_controls();
    s_axis_tvalid_i <= 1'b0;
    while (pending_controls.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (index)
      CFG_STEP_GAIN:       eta_q    = data[17:0];
      CFG_UPDATE_DAMPING:  mu_q     = data[30:0];
      CFG_CONTROL_DAMPING: lambda_q = data[30:0];
      CFG_WEIGHT_0:        rho_q[0] = data[16:0];
      CFG_WEIGHT_1:        rho_q[1] = data[16:0];
      CFG_WEIGHT_2:        rho_q[2] = data[16:0];
      CFG_WEIGHT_3:        rho_q[3] = data[16:0];
      CFG_WEIGHT_4:        rho_q[4] = data[16:0];
      default: ;  // unmapped index, write dropped
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [31:0] eta, input logic [31:0] mu,
                           input logic [31:0] lambda, input logic [31:0] rho);
    write_reg(CFG_STEP_GAIN, eta);
    write_reg(CFG_UPDATE_DAMPING, mu);
    write_reg(CFG_CONTROL_DAMPING, lambda);
    write_reg(CFG_WEIGHT_0, rho);
    write_reg(CFG_WEIGHT_1, rho);
    write_reg(CFG_WEIGHT_2, rho);
    write_reg(CFG_WEIGHT_3, rho);
    write_reg(CFG_WEIGHT_4, rho);
  endtask

  // Mostly a plant that tracks its setpoint, with full-range noise mixed in.
  task automatic send_random(input int unsigned count);
    logic signed [31:0] sp, ms;
    int unsigned kind;
    repeat (count) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        ms = last_measured + $signed($urandom_range(262143)) - 32'sd131072;
        if (ms > 32'sd8388608 || ms < -32'sd8388608) ms = $signed($urandom_range(131071));
        sp = ms + $signed($urandom_range(131071)) - 32'sd65536;
      end else if (kind < 9) begin
        sp = $signed($urandom());
        ms = $signed($urandom());
      end else begin
        sp = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        ms = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end
      send_sample(sp, ms, 1'b0, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows: measured jumps across the full range must flag a clip
  // ---------------------------------------------------------------------------
  typedef struct {
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
    logic               fixed_sat;
    logic               known_sat;
  } sample_row_t;

  localparam int DirRows = 14;
  sample_row_t directed_rows [DirRows] = '{
    '{32'sd0,          32'sd0,          1'b0, 1'b0},
    '{32'sd65536,      32'sd13107,      1'b0, 1'b0},
    '{32'sh7FFF_FFFF,  32'sh8000_0000,  1'b1, 1'b1},  // measured drops from 0.2 to min
    '{32'sh8000_0000,  32'sh7FFF_FFFF,  1'b1, 1'b1},  // min to max jump
    '{32'sh7FFF_FFFF,  32'sh8000_0000,  1'b1, 1'b1},  // max to min jump
    '{32'sd0,          32'sd0,          1'b0, 1'b0},
    '{32'sh7FFF_FFFF,  32'sh7FFF_FFFF,  1'b0, 1'b0},
    '{32'sh8000_0000,  32'sh8000_0000,  1'b1, 1'b1},  // max to min again
    '{-32'sd1,         -32'sd1,         1'b0, 1'b0},
    '{32'sh5555_5555,  32'shAAAA_AAAA,  1'b0, 1'b0},
    '{32'shAAAA_AAAA,  32'sh5555_5555,  1'b0, 1'b0},
    '{32'sd65536,      32'sd0,          1'b0, 1'b0},
    '{32'sd65536,      32'sd32768,      1'b0, 1'b0},
    '{32'sd65536,      32'sd65536,      1'b0, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    recv_hold = 1'b0;
    quiet_cycles = 0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    last_measured = '0;
    reset_controller_shadow();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration, no idling
    foreach (directed_rows[i])
      send_sample(directed_rows[i].setpoint, directed_rows[i].measured,
                  directed_rows[i].fixed_sat, directed_rows[i].known_sat);
    send_random(RandPerPhase);

    // random mid-range configuration, sender idles
    drain_controls();
    write_all($urandom_range(131072), $urandom_range(2000000) + 1,
              $urandom_range(2000000) + 1, $urandom_range(65536));
    write_reg(CFG_WEIGHT_1, $urandom_range(65536));
    send_idle_pct = 53;
    send_random(RandPerPhase);

    // low extremes: frozen gradient, zero dampings, zero weights; receiver stalls
    drain_controls();
    write_all(32'd0, 32'd0, 32'd0, 32'd0);
    write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    send_random(RandPerPhase);

    // high extremes, all-ones data exercises the width masks, then high gain with minimal dampings; both sides idle
    drain_controls();
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    send_random(RandPerPhase / 2);
    drain_controls();
    write_all(32'd131072, 32'd1, 32'd1, 32'd65536);
    send_random(RandPerPhase / 2);

    // nominal gains; receiver holds off long enough to back up the input
    drain_controls();
    write_all(32'd13107, 32'd65536, 32'd458752, 32'd45875);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        recv_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        recv_hold <= 1'b0;
      end
    join_none
    send_random(RandPerPhase);

    // random configuration, both sides idle
    drain_controls();
    write_all($urandom(), $urandom(), $urandom(), $urandom());
    write_reg(CFG_WEIGHT_0, $urandom_range(65536));
    send_idle_pct = 37;
    recv_stall_pct = 37;
    send_random(RandPerPhase);

    drain_controls();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
